>>> rtl/core/wsfc_pkg.sv
// shared types and constants for the windowed sinc coefficient generator
package wsfc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_TAPS  = 63;
  localparam int COEF_W    = FRAC_BITS + 3;
  localparam int RND_SHIFT = 60 - FRAC_BITS;

  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  localparam logic [28:0] INV_PI_Q30 = 29'd341782638;
  localparam logic [29:0] WIN_A_Q30  = 30'd579820585;
  localparam logic [28:0] WIN_B_Q30  = 29'd493921239;
  localparam logic [30:0] Q30_ONE    = 31'd1073741824;

  typedef enum logic [1:0] {
    REG_HALF_LENGTH = 2'd0,
    REG_LOW_CUTOFF  = 2'd1,
    REG_HIGH_CUTOFF = 2'd2,
    REG_FILTER_MODE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_LOWPASS  = 2'd0,
    MODE_HIGHPASS = 2'd1,
    MODE_BANDPASS = 2'd2,
    MODE_BANDSTOP = 2'd3
  } mode_t;

  // per-item control that rides alongside the arithmetic
  typedef struct packed {
    logic        tz;
    logic        oor;
    logic        h0;
    mode_t       mode;
    logic [15:0] lo_fc;
    logic [15:0] hi_fc;
  } side_t;

  // unsigned q30 product with round to nearest
  function automatic logic [30:0] mul_q30(logic [30:0] a, logic [30:0] b);
    logic [61:0] p;
    p = (a * b) + (62'd1 << 29);
    return p[60:30];
  endfunction

endpackage

>>> rtl/core/wsfc_delay.sv
// shift line that carries side data in step with the pipeline
module wsfc_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         adv,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_r[0] <= din;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign dout = sr_r[N-1];

endmodule

>>> rtl/core/wsfc_sin.sv
// seven stage sine of a q0.16 turn phase, odd polynomial, result q1.30
module wsfc_sin (
  input  logic               clk,
  input  logic               adv,
  input  logic [15:0]        phase,
  output logic signed [31:0] sine
);
  import wsfc_pkg::*;

  logic signed [17:0] x_c;
  logic [14:0]        mag_c;
  logic [30:0]        z_r  [1:6];
  logic               n_r  [1:6];
  logic [30:0]        sq_r [2:5];
  logic [30:0]        p_r  [3:6];
  logic [30:0]        r_c;
  logic signed [31:0] sine_r;

  // fold to a quarter turn
  always_comb begin
    if (phase <= 16'd16384) begin
      x_c = signed'({2'b00, phase});
    end else if (phase < 16'd49152) begin
      x_c = 18'sd32768 - signed'({2'b00, phase});
    end else begin
      x_c = signed'({2'b00, phase}) - 18'sd65536;
    end
    mag_c = x_c[17] ? 15'(-x_c) : x_c[14:0];
  end

  assign r_c = mul_q30(z_r[6], p_r[6]);

  always_ff @(posedge clk) begin
    if (adv) begin
      z_r[1] <= {mag_c, 16'b0};
      n_r[1] <= x_c[17];
      for (int i = 2; i <= 6; i++) begin
        z_r[i] <= z_r[i-1];
        n_r[i] <= n_r[i-1];
      end
      sq_r[2] <= mul_q30(z_r[1], z_r[1]);
      for (int i = 3; i <= 5; i++) begin
        sq_r[i] <= sq_r[i-1];
      end
      p_r[3] <= SIN_C7 - mul_q30(sq_r[2], SIN_C9);
      p_r[4] <= SIN_C5 - mul_q30(sq_r[3], p_r[3]);
      p_r[5] <= SIN_C3 - mul_q30(sq_r[4], p_r[4]);
      p_r[6] <= SIN_C1 - mul_q30(sq_r[5], p_r[5]);
      sine_r <= n_r[6] ? -signed'({1'b0, r_c}) : signed'({1'b0, r_c});
    end
  end

  assign sine = sine_r;

endmodule

>>> rtl/core/wsfc_div.sv
// two stage divide by a small divisor: reciprocal multiply then one correction
module wsfc_div (
  input  logic        clk,
  input  logic        adv,
  input  logic [30:0] dividend,
  input  logic [5:0]  divisor,
  output logic [31:0] quotient
);
  import wsfc_pkg::*;

  logic [32:0] recip_tab [64];
  logic [63:0] prod_c;
  logic [31:0] q0_r;
  logic [30:0] y_r;
  logic [5:0]  d_r;
  logic [37:0] back_c;
  logic [37:0] rem_c;
  logic [31:0] quot_r;

  assign recip_tab[0] = '0;
  for (genvar gi = 1; gi < 64; gi++) begin : g_recip
    localparam logic [32:0] RecipVal = 33'((64'd1 << 32) / gi);
    assign recip_tab[gi] = RecipVal;
  end

  assign prod_c = 64'(dividend * recip_tab[divisor]);
  assign back_c = 38'(q0_r * d_r);
  assign rem_c  = 38'(y_r) - back_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      q0_r   <= prod_c[63:32];
      y_r    <= dividend;
      d_r    <= divisor;
      quot_r <= (rem_c >= 38'(d_r)) ? q0_r + 32'd1 : q0_r;
    end
  end

  assign quotient = quot_r;

endmodule

>>> rtl/core/windowed_sinc_fir_coefficient_gen_top.sv
// top level: hamming windowed sinc fir coefficient generator
// an input transfer fills stage 1, and its result moves on through stage 13 into the output register,
// from which the output transfer is taken
// throughput: one tap index per cycle; all stages advance together when the
// output register is empty or being taken
// the long paths are three 7-stage sine units and three 2-stage reciprocal dividers
// reset (rst_n low, synchronous) restores the registers to their defaults and
// empties the pipeline
module windowed_sinc_fir_coefficient_gen_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [5:0] tap_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [18:0] coefficient
  output logic        out_tuser   // [0] index_out_of_range
);
  import wsfc_pkg::*;

  // configuration registers
  logic [4:0]  half_length_r;
  logic [15:0] low_cutoff_r;
  logic [15:0] high_cutoff_r;
  mode_t       filter_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_length_r <= 5'd15;
      low_cutoff_r  <= 16'd8192;
      high_cutoff_r <= 16'd16384;
      filter_mode_r <= MODE_LOWPASS;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_HALF_LENGTH: half_length_r <= cfg_wdata[4:0];
        REG_LOW_CUTOFF:  low_cutoff_r  <= cfg_wdata;
        REG_HIGH_CUTOFF: high_cutoff_r <= cfg_wdata;
        REG_FILTER_MODE: filter_mode_r <= mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output register can take a result
  logic        adv;
  logic        in_xfer;
  logic [13:1] vld_r;
  logic        out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_xfer   = in_tvalid && in_tready;

  // stage 1: offset from center, phases, window divide operands
  logic [5:0]        n_c;
  logic signed [6:0] t_c;
  logic [15:0]       t16_c;
  logic [4:0]        at_c;
  side_t             side_c;
  logic [30:0]       yw_c;
  logic [5:0]        dw_c;

  logic [15:0] ph_lo_r;
  logic [15:0] ph_hi_r;
  logic [30:0] yw_r;
  logic [5:0]  dw_r;
  logic [4:0]  at1_r;
  side_t       side1_r;

  always_comb begin
    n_c          = in_tdata[5:0];
    t_c          = signed'({1'b0, n_c}) - signed'({2'b00, half_length_r});
    t16_c        = 16'(t_c);
    at_c         = t_c[6] ? 5'(-t_c) : t_c[4:0];
    side_c.tz    = (t_c == 7'sd0);
    side_c.oor   = ({1'b0, n_c} > {1'b0, half_length_r, 1'b0}) ||
                   ({1'b0, n_c} >= 7'(MAX_TAPS));
    side_c.h0    = (half_length_r == 5'd0);
    side_c.mode  = filter_mode_r;
    side_c.lo_fc = low_cutoff_r;
    side_c.hi_fc = high_cutoff_r;
    yw_c         = 31'({n_c, 16'b0}) + 31'(half_length_r);
    dw_c         = side_c.h0 ? 6'd1 : {half_length_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_lo_r <= 16'(low_cutoff_r * t16_c);
      ph_hi_r <= 16'(high_cutoff_r * t16_c);
      yw_r    <= yw_c;
      dw_r    <= dw_c;
      at1_r   <= at_c;
      side1_r <= side_c;
    end
  end

  // side data to stage 11, tap distance to stage 9
  logic [$bits(side_t)-1:0] side11_bits;
  side_t                    side11;
  logic [4:0]               at9;

  wsfc_delay #(.W($bits(side_t)), .N(10)) u_side_dly (
    .clk (clk), .adv (adv), .din (side1_r), .dout (side11_bits)
  );
  assign side11 = side_t'(side11_bits);

  wsfc_delay #(.W(5), .N(8)) u_at_dly (
    .clk (clk), .adv (adv), .din (at1_r), .dout (at9)
  );

  // sinc terms: sine at stage 8, times 1/pi at stage 9, divided at stage 11
  logic signed [31:0] s_lo8, s_hi8;

  wsfc_sin u_sin_lo (.clk (clk), .adv (adv), .phase (ph_lo_r), .sine (s_lo8));
  wsfc_sin u_sin_hi (.clk (clk), .adv (adv), .phase (ph_hi_r), .sine (s_hi8));

  logic [30:0] mag_lo_c, mag_hi_c;
  logic [59:0] m_lo9_r, m_hi9_r;
  logic        n_lo9_r, n_hi9_r;
  logic [30:0] y_lo_c, y_hi_c;
  logic [5:0]  dt_c;
  logic [31:0] q_lo11, q_hi11;
  logic [1:0]  n11;

  assign mag_lo_c = s_lo8[31] ? 31'(-s_lo8) : s_lo8[30:0];
  assign mag_hi_c = s_hi8[31] ? 31'(-s_hi8) : s_hi8[30:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      m_lo9_r <= 60'(mag_lo_c * INV_PI_Q30);
      m_hi9_r <= 60'(mag_hi_c * INV_PI_Q30);
      n_lo9_r <= s_lo8[31];
      n_hi9_r <= s_hi8[31];
    end
  end

  // round to nearest on the divide by |t|: add half the divisor first
  assign y_lo_c = 31'((61'(m_lo9_r) + (61'(at9) << 29)) >> 30);
  assign y_hi_c = 31'((61'(m_hi9_r) + (61'(at9) << 29)) >> 30);
  assign dt_c   = (at9 == 5'd0) ? 6'd1 : {1'b0, at9};

  wsfc_div u_div_lo (
    .clk (clk), .adv (adv), .dividend (y_lo_c), .divisor (dt_c), .quotient (q_lo11)
  );
  wsfc_div u_div_hi (
    .clk (clk), .adv (adv), .dividend (y_hi_c), .divisor (dt_c), .quotient (q_hi11)
  );

  wsfc_delay #(.W(2), .N(2)) u_sign_dly (
    .clk (clk), .adv (adv), .din ({n_hi9_r, n_lo9_r}), .dout (n11)
  );

  // window: phase divide at stage 3, cosine at stage 10, weight at stage 11
  logic [31:0]        qw3;
  logic [15:0]        phw_c;
  logic signed [31:0] sw10;
  logic [30:0]        magw_c;
  logic [59:0]        pw_c;
  logic [30:0]        rw_c;
  logic signed [31:0] w11_r;

  wsfc_div u_div_win (
    .clk (clk), .adv (adv), .dividend (yw_r), .divisor (dw_r), .quotient (qw3)
  );

  // cosine is sine a quarter turn ahead
  assign phw_c = qw3[15:0] + 16'd16384;

  wsfc_sin u_sin_win (.clk (clk), .adv (adv), .phase (phw_c), .sine (sw10));

  assign magw_c = sw10[31] ? 31'(-sw10) : sw10[30:0];
  assign pw_c   = 60'(magw_c * WIN_B_Q30) + (60'd1 << 29);
  assign rw_c   = {1'b0, pw_c[59:30]};

  always_ff @(posedge clk) begin
    if (adv) begin
      w11_r <= sw10[31] ? signed'(32'(WIN_A_Q30)) + signed'({1'b0, rw_c})
                        : signed'(32'(WIN_A_Q30)) - signed'({1'b0, rw_c});
    end
  end

  // stage 11 to 12: pick the response for the filter mode
  logic signed [33:0] lo_c, hi_c, delta_c, v_c;
  logic signed [31:0] wt_c;
  logic signed [33:0] v12_r;
  logic signed [31:0] w12_r;
  logic               oor12_r;

  always_comb begin
    if (side11.tz) begin
      lo_c    = signed'(34'({side11.lo_fc, 15'b0}));
      hi_c    = signed'(34'({side11.hi_fc, 15'b0}));
      delta_c = signed'(34'(Q30_ONE));
    end else begin
      lo_c    = n11[0] ? -signed'(34'(q_lo11)) : signed'(34'(q_lo11));
      hi_c    = n11[1] ? -signed'(34'(q_hi11)) : signed'(34'(q_hi11));
      delta_c = '0;
    end
    case (side11.mode)
      MODE_LOWPASS:  v_c = lo_c;
      MODE_HIGHPASS: v_c = delta_c - lo_c;
      MODE_BANDPASS: v_c = hi_c - lo_c;
      default:       v_c = delta_c - (hi_c - lo_c);
    endcase
    // single tap filter: window is exactly one
    wt_c = side11.h0 ? signed'(32'(Q30_ONE)) : w11_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v12_r   <= v_c;
      w12_r   <= wt_c;
      oor12_r <= side11.oor;
    end
  end

  // stage 13: sign-magnitude product
  logic [32:0] vmag_c;
  logic [30:0] wmag_c;
  logic [63:0] mag13_r;
  logic        neg13_r;
  logic        oor13_r;

  assign vmag_c = v12_r[33] ? 33'(-v12_r) : v12_r[32:0];
  assign wmag_c = w12_r[31] ? 31'(-w12_r) : w12_r[30:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      mag13_r <= 64'(vmag_c * wmag_c);
      neg13_r <= v12_r[33] ^ w12_r[31];
      oor13_r <= oor12_r;
    end
  end

  // output: round half away from zero, saturate to q2.16
  localparam logic [20:0] LimPos = 21'((64'd1 << (FRAC_BITS + 2)) - 64'd1);
  localparam logic [20:0] LimNeg = 21'(64'd1 << (FRAC_BITS + 2));

  logic [64:0]       rsum_c;
  logic [20:0]       rq_c;
  logic [20:0]       sat_c;
  logic [COEF_W-1:0] coef_c;
  logic [COEF_W-1:0] coef_r;
  logic              oor_out_r;

  always_comb begin
    rsum_c = 65'(mag13_r) + (65'd1 << (RND_SHIFT - 1));
    rq_c   = 21'(rsum_c >> RND_SHIFT);
    if (neg13_r) begin
      sat_c  = (rq_c > LimNeg) ? LimNeg : rq_c;
      coef_c = COEF_W'(-sat_c);
    end else begin
      sat_c  = (rq_c > LimPos) ? LimPos : rq_c;
      coef_c = COEF_W'(sat_c);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coef_r    <= oor13_r ? '0 : coef_c;
      oor_out_r <= oor13_r;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[12:1], in_xfer};
      out_valid_r <= vld_r[13];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 24'(coef_r);
  assign out_tuser  = oor_out_r;

  // an out of range result always carries a zero coefficient
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tuser |-> out_tdata == 24'd0)
    else $error("out of range transfer with nonzero coefficient");

  // a stall freezes the valid bits of every stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // an accepted index enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> vld_r[1])
    else $error("accepted index lost at entry");

  // the last stage never drops a result into a full stalled output
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[13] && adv |=> out_valid_r)
    else $error("result lost at output register");

endmodule
